// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, opcodes, command classes and the queued command type.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Default grid geometry and queue depth.
  localparam int GRID_COLS_DEFAULT   = 80;
  localparam int GRID_ROWS_DEFAULT   = 25;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;
  localparam logic [7:0] ERROR_ATTR_RESET   = 8'd244;

  // Character codes and attributes.
  localparam logic [7:0] CODE_NEWLINE  = 8'h0A;
  localparam logic [7:0] CODE_BLANK    = 8'h08;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_ERROR    = 8'h45;
  localparam logic [7:0] ATTR_FALLBACK = 8'd15;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_BACKSPACE = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // Command classes produced by the front end.
  typedef enum logic [2:0] {
    K_CHAR,
    K_NEWLINE,
    K_BLANK,
    K_BACKSPACE,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
    logic       col_auto;
    logic [6:0] col_val;
    logic       row_auto;
    logic [4:0] row_val;
  } cmd_t;

endpackage

// ===== sv/tcw_if.sv =====
// ----------------------------------------------------------------------------
// Text console writer channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [7:0]        char_code;
  logic signed [7:0] col_pick;
  logic signed [5:0] row_pick;

  modport source (output valid, output opcode, output char_code, output col_pick,
                  output row_pick, input ready);
  modport sink   (input valid, input opcode, input char_code, input col_pick,
                  input row_pick, output ready);
endinterface

interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [7:0] read_symbol;
  logic [7:0] read_attr;
  logic       range_error;

  modport source (output valid, output cursor_col, output cursor_row, output read_symbol,
                  output read_attr, output range_error, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row, input read_symbol,
                  input read_attr, input range_error, output ready);
endinterface

// ===== sv/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console writer core
// Text-mode console engine with a cell grid, a cursor, scrolling and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (opcode, char_code, col_pick, row_pick)
//   and each one produces exactly one response on the rsp channel (cursor
//   position after the operation, read cell contents, range error flag).
//   A transfer happens on a clock edge with valid and ready both high.
//   The configuration port writes default_attr (index 0) and error_attr
//   (index 1) on any edge with cfg_we high; write it only while idle.
// Pipeline and sweeps:
//   A request is stored in the command queue until the back end pops it.
//   Put and backspace load the response register when popped; a read
//   first passes through the registered read port of the cell memory.
//   Clear and scroll sweep the grid through the single write port of the
//   cell memory, one cell a cycle.
// Reset and stalls:
//   After reset the cell memory is zeroed in a pass over every cell;
//   req.ready stays low during that pass. When the receiver stalls,
//   the response register holds and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
  parameter int GRID_COLS   = tcw_pkg::GRID_COLS_DEFAULT,
  parameter int GRID_ROWS   = tcw_pkg::GRID_ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  tcw_req_if.sink                        req,
  tcw_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Front to queue.
  logic          push_valid;
  logic          push_ready;
  tcw_pkg::cmd_t push_data;

  // Queue to back end.
  logic          q_valid;
  logic          q_ready;
  tcw_pkg::cmd_t q_data;

  // The back end holds off new requests during the post-reset clearing pass.
  logic          init_busy;

  // The front end decodes each request into a command class and keeps the
  // raw picks; cursor-relative positions are resolved in the back end,
  // since only it knows the cursor at the time the command executes.
  tcw_front u_front (
    .req        (req),
    .init_busy  (init_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue lets the front end keep taking transfers while the back end
  // is busy with a sweep or waiting on a stalled receiver.
  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // The back end owns the cell memory, the cursor, the attribute registers
  // and the response register.
  tcw_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .rsp       (rsp),
    .init_busy (init_busy)
  );

endmodule

// ===== sv/tcw_front.sv =====
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts requests and classifies them into queued commands.
// ----------------------------------------------------------------------------
module tcw_front (
  tcw_req_if.sink        req,
  input  logic           init_busy,
  output logic           push_valid,
  input  logic           push_ready,
  output tcw_pkg::cmd_t  push_data
);

  tcw_pkg::kind_t kind;

  // Requests are held off while the cell memory is being cleared after reset.
  assign req.ready  = push_ready && !init_busy;
  assign push_valid = req.valid && !init_busy;

  always_comb begin
    case (tcw_pkg::op_t'(req.opcode))
      tcw_pkg::OP_PUT: begin
        if (req.char_code == tcw_pkg::CODE_NEWLINE) begin
          kind = tcw_pkg::K_NEWLINE;
        end else if (req.char_code == tcw_pkg::CODE_BLANK) begin
          kind = tcw_pkg::K_BLANK;
        end else begin
          kind = tcw_pkg::K_CHAR;
        end
      end
      tcw_pkg::OP_BACKSPACE: kind = tcw_pkg::K_BACKSPACE;
      tcw_pkg::OP_CLEAR:     kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ:      kind = tcw_pkg::K_READ;
      default:               kind = tcw_pkg::K_READ;
    endcase
  end

  // A negative pick selects the cursor coordinate.
  always_comb begin
    push_data.kind     = kind;
    push_data.code     = req.char_code;
    push_data.col_auto = req.col_pick[7];
    push_data.col_val  = req.col_pick[6:0];
    push_data.row_auto = req.row_pick[5];
    push_data.row_val  = req.row_pick[4:0];
  end

endmodule

// ===== sv/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// Text console writer command queue
// Small FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcw_queue #(
  parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tcw_pkg::cmd_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcw_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/tcw_back.sv =====
// ----------------------------------------------------------------------------
// Text console writer back end
// Owns the cell memory and cursor, executes commands, runs fill and scroll
// sweeps, and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int GRID_COLS = tcw_pkg::GRID_COLS_DEFAULT,
  parameter int GRID_ROWS = tcw_pkg::GRID_ROWS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  tcw_pkg::cmd_t                  q_data,
  tcw_rsp_if.source                      rsp,
  output logic                           init_busy
);

  localparam int N      = GRID_COLS * GRID_ROWS;
  localparam int MOVE_N = N - GRID_COLS;
  localparam int ADDR_W = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_READ, S_SCROLL} state_t;

  // Cell memory: symbol in the low byte, attribute in the high byte.
  logic [15:0]       mem [N];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [7:0] default_attr;
  logic [7:0] error_attr;
  logic [7:0] write_attr;

  state_t            state, state_next;
  logic [CNT_W-1:0]  k, k_next;
  logic [15:0]       fill_data, fill_data_next;
  logic              init_done, init_done_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;

  logic       out_valid, out_valid_next;
  logic [6:0] out_col, out_col_next;
  logic [4:0] out_row, out_row_next;
  logic [7:0] out_sym, out_sym_next;
  logic [7:0] out_attr, out_attr_next;
  logic       out_err, out_err_next;

  logic              out_free;
  logic              pop;
  logic [7:0]        res_col;
  logic [6:0]        res_row;
  logic              out_of_range;
  logic [COL_W-1:0]  pick_col;
  logic [ROW_W-1:0]  pick_row;
  logic [ADDR_W-1:0] pick_addr;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [ADDR_W-1:0] bs_addr;
  logic [CNT_W:0]    scroll_rd;
  logic [CNT_W-1:0]  k_prev;

  assign init_busy = !init_done;
  assign out_free  = !out_valid || rsp.ready;
  assign pop       = (state == S_IDLE) && q_valid && out_free;
  assign q_ready   = pop;

  assign write_attr = (default_attr != 8'd0) ? default_attr : tcw_pkg::ATTR_FALLBACK;

  // Resolve picked position against the cursor and check it against the grid.
  assign res_col      = q_data.col_auto ? 8'(cur_col) : {1'b0, q_data.col_val};
  assign res_row      = q_data.row_auto ? 7'(cur_row) : {2'b00, q_data.row_val};
  assign out_of_range = (res_col >= 8'(GRID_COLS)) || (res_row >= 7'(GRID_ROWS));
  assign pick_col     = res_col[COL_W-1:0];
  assign pick_row     = res_row[ROW_W-1:0];
  assign pick_addr    = ADDR_W'(pick_row) * ADDR_W'(GRID_COLS) + ADDR_W'(pick_col);

  // Backspace target: one cell back, stopping at the first cell.
  always_comb begin
    if (cur_col != '0) begin
      bs_col = cur_col - COL_W'(1);
      bs_row = cur_row;
    end else if (cur_row != '0) begin
      bs_col = COL_W'(GRID_COLS - 1);
      bs_row = cur_row - ROW_W'(1);
    end else begin
      bs_col = '0;
      bs_row = '0;
    end
  end
  assign bs_addr = ADDR_W'(bs_row) * ADDR_W'(GRID_COLS) + ADDR_W'(bs_col);

  assign scroll_rd = (CNT_W+1)'(k) + (CNT_W+1)'(GRID_COLS);
  assign k_prev    = k - CNT_W'(1);

  always_comb begin
    state_next     = state;
    k_next         = k;
    fill_data_next = fill_data;
    init_done_next = init_done;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    out_valid_next = out_valid && !rsp.ready;
    out_col_next   = out_col;
    out_row_next   = out_row;
    out_sym_next   = out_sym;
    out_attr_next  = out_attr;
    out_err_next   = out_err;
    mem_we         = 1'b0;
    mem_waddr      = pick_addr;
    mem_wdata      = 16'h0000;
    mem_re         = 1'b0;
    mem_raddr      = pick_addr;

    case (state)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = k[ADDR_W-1:0];
        mem_wdata = fill_data;
        if (k == CNT_W'(N - 1)) begin
          state_next     = S_IDLE;
          k_next         = '0;
          init_done_next = 1'b1;
        end else begin
          k_next = k + CNT_W'(1);
        end
      end

      S_SCROLL: begin
        // Read row below through the registered read port and write it one row up; bottom row zeroed.
        if (k < CNT_W'(MOVE_N)) begin
          mem_re    = 1'b1;
          mem_raddr = scroll_rd[ADDR_W-1:0];
        end
        if (k != '0) begin
          mem_we    = 1'b1;
          mem_waddr = k_prev[ADDR_W-1:0];
          mem_wdata = (k <= CNT_W'(MOVE_N)) ? rdata : 16'h0000;
        end
        if (k == CNT_W'(N)) begin
          state_next = S_IDLE;
          k_next     = '0;
        end else begin
          k_next = k + CNT_W'(1);
        end
      end

      S_READ: begin
        out_valid_next = 1'b1;
        out_col_next   = 7'(cur_col);
        out_row_next   = 5'(cur_row);
        out_sym_next   = rdata[7:0];
        out_attr_next  = rdata[15:8];
        out_err_next   = 1'b0;
        state_next     = S_IDLE;
      end

      S_IDLE: begin
        if (pop) begin
          out_sym_next  = 8'd0;
          out_attr_next = 8'd0;
          out_err_next  = 1'b0;
          case (q_data.kind)
            tcw_pkg::K_CHAR, tcw_pkg::K_NEWLINE, tcw_pkg::K_BLANK: begin
              if (out_of_range) begin
                mem_we       = 1'b1;
                mem_waddr    = ADDR_W'(N - 1);
                mem_wdata    = {error_attr, tcw_pkg::CHAR_ERROR};
                out_err_next = 1'b1;
              end else if (q_data.kind == tcw_pkg::K_BLANK) begin
                mem_we       = 1'b1;
                mem_wdata    = {write_attr, tcw_pkg::CHAR_SPACE};
                cur_col_next = pick_col;
                cur_row_next = pick_row;
              end else begin
                if (q_data.kind == tcw_pkg::K_CHAR) begin
                  mem_we    = 1'b1;
                  mem_wdata = {write_attr, q_data.code};
                end
                if ((q_data.kind == tcw_pkg::K_CHAR) &&
                    (pick_col != COL_W'(GRID_COLS - 1))) begin
                  cur_col_next = pick_col + COL_W'(1);
                  cur_row_next = pick_row;
                end else begin
                  cur_col_next = '0;
                  if (pick_row == ROW_W'(GRID_ROWS - 1)) begin
                    cur_row_next = pick_row;
                    state_next   = S_SCROLL;
                    k_next       = '0;
                  end else begin
                    cur_row_next = pick_row + ROW_W'(1);
                  end
                end
              end
            end
            tcw_pkg::K_BACKSPACE: begin
              mem_we       = 1'b1;
              mem_waddr    = bs_addr;
              mem_wdata    = {write_attr, tcw_pkg::CHAR_SPACE};
              cur_col_next = bs_col;
              cur_row_next = bs_row;
            end
            tcw_pkg::K_CLEAR: begin
              fill_data_next = {default_attr, tcw_pkg::CHAR_SPACE};
              state_next     = S_FILL;
              k_next         = '0;
              cur_col_next   = '0;
              cur_row_next   = '0;
            end
            tcw_pkg::K_READ: begin
              if (out_of_range) begin
                out_err_next = 1'b1;
              end else begin
                mem_re     = 1'b1;
                state_next = S_READ;
              end
            end
            default: begin
              out_err_next = 1'b0;
            end
          endcase
          out_valid_next = !((q_data.kind == tcw_pkg::K_READ) && !out_of_range);
          out_col_next   = 7'(cur_col_next);
          out_row_next   = 5'(cur_row_next);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= tcw_pkg::DEFAULT_ATTR_RESET;
      error_attr   <= tcw_pkg::ERROR_ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tcw_pkg::REG_DEFAULT_ATTR: default_attr <= cfg_data;
        tcw_pkg::REG_ERROR_ATTR:   error_attr   <= cfg_data;
        default: begin
          error_attr <= error_attr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      k         <= '0;
      fill_data <= 16'h0000;
      init_done <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      k         <= k_next;
      fill_data <= fill_data_next;
      init_done <= init_done_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      out_valid <= out_valid_next;
    end
    out_col  <= out_col_next;
    out_row  <= out_row_next;
    out_sym  <= out_sym_next;
    out_attr <= out_attr_next;
    out_err  <= out_err_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.cursor_col  = out_col;
  assign rsp.cursor_row  = out_row;
  assign rsp.read_symbol = out_sym;
  assign rsp.read_attr   = out_attr;
  assign rsp.range_error = out_err;

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (cur_col < COL_W'(GRID_COLS - 1) || cur_col == COL_W'(GRID_COLS - 1)) &&
    (cur_row < ROW_W'(GRID_ROWS - 1) || cur_row == ROW_W'(GRID_ROWS - 1)))
    else $error("cursor left the grid");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("read data arrived while response register was occupied");

  a_init_in_fill: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> (state == S_FILL))
    else $error("initial clear left before completion");

  a_pop_after_scroll: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && k == CNT_W'(N)) |=> (state == S_IDLE && k == '0))
    else $error("scroll sweep did not finish cleanly");

endmodule
